// ===== sv/cfp_pkg.sv =====
// Package for the command frame parser: character codes, enums and the result struct.
// No dependencies; cfp_core, the parser unit and the testbench refer to it by scoped names.
package cfp_pkg;

    localparam logic [7:0] CH_START = 8'h2C;
    localparam logic [7:0] CH_STOP  = 8'h2E;
    localparam logic [7:0] CH_MARK  = 8'h21;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    localparam int SLOT_COUNT = 5;

    typedef enum logic [1:0] {
        PH_SKIP   = 2'd0,
        PH_DIGITS = 2'd1,
        PH_DONE   = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        KIND_NAME     = 2'd0,
        KIND_STORED   = 2'd1,
        KIND_BAD_SLOT = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind       frame_kind;
        logic [7:0]  slot;
        logic [15:0] value;
        logic [63:0] text_chars;
        logic [7:0]  text_length;
        logic        text_overflow;
    } t_result;

endpackage

// ===== sv/cfp_if.sv =====
// Handshake channels of the command frame parser: received bytes in, frame results out.
// Payload widths follow the fixed field widths; no package dependency.
interface cfp_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cfp_res_if;
    logic               valid;
    logic               ready;
    logic [1:0]         frame_kind;
    logic [7:0]         slot;
    logic signed [15:0] value;
    logic [63:0]        text_chars;
    logic [7:0]         text_length;
    logic               text_overflow;

    modport source (output valid, output frame_kind, output slot, output value,
                    output text_chars, output text_length, output text_overflow,
                    input ready);
    modport sink   (input valid, input frame_kind, input slot, input value,
                    input text_chars, input text_length, input text_overflow,
                    output ready);
endinterface

// ===== sv/cfp_core.sv =====
// Frame state, text buffer and running decimal parse; one byte per step.
// Presents the result of a stop byte combinationally from the current state. Uses cfp_pkg.
module cfp_core #(
    parameter int NAME_MAX = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [7:0]       i_byte,
    output cfp_pkg::t_result o_result
);

    logic              r_in_frame, n_in_frame;
    logic              r_value_mode, n_value_mode;
    logic              r_expect_slot, n_expect_slot;
    logic [7:0]        r_slot_number, n_slot_number;
    logic [7:0]        r_text_buf [NAME_MAX];
    logic [7:0]        r_text_count, n_text_count;
    logic [15:0]       r_acc, n_acc;
    cfp_pkg::t_phase   r_phase, n_phase;
    logic              r_neg, n_neg;

    logic              w_is_start, w_is_mark, w_is_stop, w_ordinary;
    logic              w_is_digit, w_is_space;
    logic [15:0]       w_digit;
    logic              w_take_slot, w_push;
    logic [15:0]       w_value;
    logic [63:0]       w_chars;
    logic              w_slot_ok;

    assign w_is_start = (i_byte == cfp_pkg::CH_START);
    assign w_is_mark  = (i_byte == cfp_pkg::CH_MARK);
    assign w_is_stop  = (i_byte == cfp_pkg::CH_STOP);
    assign w_ordinary = !w_is_start && !w_is_mark && !w_is_stop;
    assign w_is_digit = (i_byte >= cfp_pkg::CH_ZERO) && (i_byte <= cfp_pkg::CH_NINE);
    assign w_is_space = (i_byte == cfp_pkg::CH_SPACE) ||
                        ((i_byte >= cfp_pkg::CH_TAB) && (i_byte <= cfp_pkg::CH_CR));
    assign w_digit    = {12'd0, 4'(i_byte - cfp_pkg::CH_ZERO)};

    assign w_take_slot = i_step && r_in_frame && w_ordinary && r_value_mode && r_expect_slot;
    assign w_push      = i_step && r_in_frame && w_ordinary && !(r_value_mode && r_expect_slot);

    always_comb begin
        n_in_frame    = r_in_frame;
        n_value_mode  = r_value_mode;
        n_expect_slot = r_expect_slot;
        n_slot_number = r_slot_number;
        if (i_step && w_is_start) begin
            n_in_frame = 1'b1;
        end else if (i_step && w_is_mark) begin
            n_value_mode  = 1'b1;
            n_expect_slot = 1'b1;
        end else if (i_step && w_is_stop) begin
            n_in_frame    = 1'b0;
            n_value_mode  = 1'b0;
            n_expect_slot = 1'b0;
            n_slot_number = 8'd0;
        end else if (w_take_slot) begin
            n_slot_number = i_byte - cfp_pkg::CH_ZERO;
            n_expect_slot = 1'b0;
        end
    end

    always_comb begin
        n_text_count = r_text_count;
        if (i_step && w_is_start) begin
            n_text_count = 8'd0;
        end else if (w_push && r_text_count != 8'hFF) begin
            n_text_count = r_text_count + 8'd1;
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_acc   = r_acc;
        n_neg   = r_neg;
        if (i_step && w_is_start) begin
            n_phase = cfp_pkg::PH_SKIP;
            n_acc   = 16'd0;
            n_neg   = 1'b0;
        end else if (w_push) begin
            unique case (r_phase)
                cfp_pkg::PH_SKIP: begin
                    if (w_is_space) begin
                        n_phase = cfp_pkg::PH_SKIP;
                    end else if (i_byte == cfp_pkg::CH_MINUS) begin
                        n_neg   = 1'b1;
                        n_phase = cfp_pkg::PH_DIGITS;
                    end else if (i_byte == cfp_pkg::CH_PLUS) begin
                        n_phase = cfp_pkg::PH_DIGITS;
                    end else if (w_is_digit) begin
                        n_acc   = w_digit;
                        n_phase = cfp_pkg::PH_DIGITS;
                    end else begin
                        n_phase = cfp_pkg::PH_DONE;
                    end
                end
                cfp_pkg::PH_DIGITS: begin
                    if (w_is_digit) begin
                        n_acc = (r_acc << 3) + (r_acc << 1) + w_digit;
                    end else begin
                        n_phase = cfp_pkg::PH_DONE;
                    end
                end
                cfp_pkg::PH_DONE: begin
                    n_phase = cfp_pkg::PH_DONE;
                end
                default: begin
                    n_phase = cfp_pkg::PH_DONE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame    <= 1'b0;
            r_value_mode  <= 1'b0;
            r_expect_slot <= 1'b0;
            r_slot_number <= 8'd0;
            r_text_count  <= 8'd0;
            r_acc         <= 16'd0;
            r_phase       <= cfp_pkg::PH_SKIP;
            r_neg         <= 1'b0;
        end else begin
            r_in_frame    <= n_in_frame;
            r_value_mode  <= n_value_mode;
            r_expect_slot <= n_expect_slot;
            r_slot_number <= n_slot_number;
            r_text_count  <= n_text_count;
            r_acc         <= n_acc;
            r_phase       <= n_phase;
            r_neg         <= n_neg;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NAME_MAX; i++) begin
            if (w_push && r_text_count == 8'(i)) begin
                r_text_buf[i] <= i_byte;
            end
        end
    end

    always_comb begin
        w_chars = 64'd0;
        for (int i = 0; i < NAME_MAX; i++) begin
            if (8'(i) < r_text_count) begin
                w_chars[8*i +: 8] = r_text_buf[i];
            end
        end
    end

    assign w_value   = r_neg ? (16'd0 - r_acc) : r_acc;
    assign w_slot_ok = (r_slot_number >= 8'd1) &&
                       (r_slot_number <= 8'(cfp_pkg::SLOT_COUNT));

    always_comb begin
        o_result.text_chars    = w_chars;
        o_result.text_length   = r_text_count;
        o_result.text_overflow = (r_text_count > 8'(NAME_MAX));
        if (r_value_mode) begin
            o_result.frame_kind = w_slot_ok ? cfp_pkg::KIND_STORED : cfp_pkg::KIND_BAD_SLOT;
            o_result.slot       = r_slot_number;
            o_result.value      = w_value;
        end else begin
            o_result.frame_kind = cfp_pkg::KIND_NAME;
            o_result.slot       = 8'd0;
            o_result.value      = 16'd0;
        end
    end

    a_slot_needs_value_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_expect_slot |-> r_value_mode)
        else $error("slot expected outside value mode");

    a_stop_clears_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && w_is_stop |=> !r_in_frame && !r_value_mode && r_slot_number == 8'd0)
        else $error("frame flags not cleared after stop");

    a_start_clears_parse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && w_is_start |=> r_text_count == 8'd0 && r_acc == 16'd0 && !r_neg &&
                                 r_phase == cfp_pkg::PH_SKIP)
        else $error("parse not cleared after start");

endmodule

// ===== sv/command_frame_parser_unit.sv =====
// Command frame parser: input byte register, parser core and result register.
// A stop byte is held in the input byte register, then its result is captured in the result register.
// Throughput: one byte per cycle; a stop byte stalls only while the result register
// is full and not taken. Reset (i_rst_n low, synchronous) empties both registers,
// closes any frame and clears the parse; text buffer contents are left as they are.
module command_frame_parser_unit #(
    parameter int NAME_MAX = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cfp_rx_if.sink     i_rx,
    cfp_res_if.source  o_res
);

    logic             r_in_vld, n_in_vld;
    logic [7:0]       r_in_byte;
    logic             r_out_vld, n_out_vld;
    cfp_pkg::t_result r_res;
    cfp_pkg::t_result w_result;
    logic             w_in_stop, w_advance;

    assign w_in_stop = (r_in_byte == cfp_pkg::CH_STOP);
    assign w_advance = r_in_vld && (!w_in_stop || !r_out_vld || o_res.ready);
    assign i_rx.ready = !r_in_vld || w_advance;

    cfp_core #(
        .NAME_MAX (NAME_MAX)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_advance),
        .i_byte   (r_in_byte),
        .o_result (w_result)
    );

    always_comb begin
        n_in_vld = r_in_vld;
        if (i_rx.valid && i_rx.ready) begin
            n_in_vld = 1'b1;
        end else if (w_advance) begin
            n_in_vld = 1'b0;
        end
    end

    always_comb begin
        n_out_vld = r_out_vld;
        if (w_advance && w_in_stop) begin
            n_out_vld = 1'b1;
        end else if (o_res.ready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= n_in_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_in_byte <= i_rx.rx_byte;
        end
        if (w_advance && w_in_stop) begin
            r_res <= w_result;
        end
    end

    assign o_res.valid         = r_out_vld;
    assign o_res.frame_kind    = r_res.frame_kind;
    assign o_res.slot          = r_res.slot;
    assign o_res.value         = r_res.value;
    assign o_res.text_chars    = r_res.text_chars;
    assign o_res.text_length   = r_res.text_length;
    assign o_res.text_overflow = r_res.text_overflow;

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !o_res.ready |=> r_out_vld && $stable(r_res))
        else $error("pending result dropped or changed");

    a_stall_holds_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && !w_advance |=> r_in_vld && $stable(r_in_byte))
        else $error("stalled byte lost");

    a_stall_only_on_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && !w_advance |-> w_in_stop && r_out_vld && !o_res.ready)
        else $error("input stalled without a full result register");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_in_vld && !r_out_vld)
        else $error("registers not emptied by reset");

endmodule

// ===== verif/command_frame_parser_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for command_frame_parser_unit: drives byte streams of frames,
// predicts each frame result and compares every field. Needs cfp_pkg and the cfp_if channels.
module command_frame_parser_unit_tb;

    localparam int NAME_MAX     = 8;
    localparam int BUF_IW       = $clog2(NAME_MAX);
    localparam int ITEM_TARGET  = 1700;
    localparam int CALM_TAIL    = 200;
    localparam int DRAIN_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 200000;

    logic i_clk;
    logic i_rst_n;

    cfp_rx_if  rx_ch ();
    cfp_res_if res_ch ();

    command_frame_parser_unit #(
        .NAME_MAX(NAME_MAX)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_rx   (rx_ch),
        .o_res  (res_ch)
    );

    logic [7:0]       pending_bytes[$];
    cfp_pkg::t_result frame_results_due[$];

    logic            in_frame    = 1'b0;
    logic            value_mode  = 1'b0;
    logic            want_slot   = 1'b0;
    logic [7:0]      slot_no     = 8'd0;
    logic [7:0]      text_buf[NAME_MAX];
    logic [7:0]      text_cnt    = 8'd0;
    logic [31:0]     number_acc  = 32'd0;
    cfp_pkg::t_phase parse_phase = cfp_pkg::PH_SKIP;
    logic            negative    = 1'b0;

    int error_count   = 0;
    int bytes_taken   = 0;
    int results_seen  = 0;
    int stored_seen   = 0;
    int bad_slot_seen = 0;
    int long_seen     = 0;
    int cycle_count   = 0;
    int send_gap      = 0;
    int sink_gap      = 0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic bit idling_allowed();
        return pending_bytes.size() >= CALM_TAIL && ((pending_bytes.size() / 150) % 3 != 0);
    endfunction

    // Apply one accepted byte to the predicted parser state.
    task automatic advance_parser(input logic [7:0] c);
        cfp_pkg::t_result r;
        logic [31:0]      v;
        logic             digit;
        logic             space;
        int               i;
        digit = (c >= cfp_pkg::CH_ZERO) && (c <= cfp_pkg::CH_NINE);
        space = (c == cfp_pkg::CH_SPACE) || (c >= cfp_pkg::CH_TAB && c <= cfp_pkg::CH_CR);
        if (c == cfp_pkg::CH_START) begin
            in_frame    = 1'b1;
            text_cnt    = 8'd0;
            number_acc  = 32'd0;
            parse_phase = cfp_pkg::PH_SKIP;
            negative    = 1'b0;
        end else if (c == cfp_pkg::CH_MARK) begin
            value_mode = 1'b1;
            want_slot  = 1'b1;
        end else if (c == cfp_pkg::CH_STOP) begin
            r = '0;
            for (i = 0; i < NAME_MAX; i++) begin
                if (i < text_cnt) r.text_chars[8*i +: 8] = text_buf[i];
            end
            if (value_mode) begin
                v       = negative ? (32'd0 - number_acc) : number_acc;
                r.slot  = slot_no;
                r.value = v[15:0];
                r.frame_kind = (slot_no >= 1 && slot_no <= cfp_pkg::SLOT_COUNT)
                               ? cfp_pkg::KIND_STORED : cfp_pkg::KIND_BAD_SLOT;
            end else begin
                r.frame_kind = cfp_pkg::KIND_NAME;
            end
            r.text_length   = text_cnt;
            r.text_overflow = (text_cnt > NAME_MAX);
            frame_results_due.push_back(r);
            slot_no    = 8'd0;
            in_frame   = 1'b0;
            value_mode = 1'b0;
            want_slot  = 1'b0;
        end else if (in_frame) begin
            if (value_mode && want_slot) begin
                slot_no   = c - cfp_pkg::CH_ZERO;
                want_slot = 1'b0;
            end else begin
                if (text_cnt < NAME_MAX) text_buf[BUF_IW'(text_cnt)] = c;
                if (text_cnt != 8'hFF) text_cnt = text_cnt + 8'd1;
                case (parse_phase)
                    cfp_pkg::PH_SKIP: begin
                        if (c == cfp_pkg::CH_MINUS) begin
                            negative    = 1'b1;
                            parse_phase = cfp_pkg::PH_DIGITS;
                        end else if (c == cfp_pkg::CH_PLUS) begin
                            parse_phase = cfp_pkg::PH_DIGITS;
                        end else if (digit) begin
                            number_acc  = 32'(c - cfp_pkg::CH_ZERO);
                            parse_phase = cfp_pkg::PH_DIGITS;
                        end else if (!space) begin
                            parse_phase = cfp_pkg::PH_DONE;
                        end
                    end
                    cfp_pkg::PH_DIGITS: begin
                        if (digit) number_acc = number_acc * 32'd10 + 32'(c - cfp_pkg::CH_ZERO);
                        else parse_phase = cfp_pkg::PH_DONE;
                    end
                    default: ;
                endcase
            end
        end
    endtask

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255));
        while (b == cfp_pkg::CH_START || b == cfp_pkg::CH_STOP || b == cfp_pkg::CH_MARK);
        return b;
    endfunction

    function automatic logic [7:0] control_byte();
        case ($urandom_range(0, 2))
            0: return cfp_pkg::CH_START;
            1: return cfp_pkg::CH_STOP;
            default: return cfp_pkg::CH_MARK;
        endcase
    endfunction

    task automatic add_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) pending_bytes.push_back(s[i]);
    endtask

    task automatic add_value_frame();
        int i;
        int n;
        if ($urandom_range(0, 3) == 0) begin
            pending_bytes.push_back(cfp_pkg::CH_MARK);
            pending_bytes.push_back(cfp_pkg::CH_START);
        end else begin
            pending_bytes.push_back(cfp_pkg::CH_START);
            pending_bytes.push_back(cfp_pkg::CH_MARK);
        end
        if ($urandom_range(0, 9) == 0) pending_bytes.push_back(plain_byte());
        else pending_bytes.push_back(cfp_pkg::CH_ZERO + 8'($urandom_range(0, 6)));
        n = $urandom_range(0, 2);
        for (i = 0; i < n; i++) begin
            if ($urandom_range(0, 1) == 0) pending_bytes.push_back(cfp_pkg::CH_SPACE);
            else pending_bytes.push_back(cfp_pkg::CH_TAB + 8'($urandom_range(0, 4)));
        end
        case ($urandom_range(0, 3))
            0: pending_bytes.push_back(cfp_pkg::CH_MINUS);
            1: pending_bytes.push_back(cfp_pkg::CH_PLUS);
            default: ;
        endcase
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 5);
        for (i = 0; i < n; i++)
            pending_bytes.push_back(cfp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
        if ($urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 3);
            for (i = 0; i < n; i++) pending_bytes.push_back(plain_byte());
        end
        pending_bytes.push_back(cfp_pkg::CH_STOP);
    endtask

    task automatic add_name_frame(input int len);
        int i;
        int mark_at;
        mark_at = ($urandom_range(0, 7) == 0) ? len / 2 : -1;
        pending_bytes.push_back(cfp_pkg::CH_START);
        for (i = 0; i < len; i++) begin
            if (i == mark_at) pending_bytes.push_back(cfp_pkg::CH_MARK);
            pending_bytes.push_back(plain_byte());
        end
        pending_bytes.push_back(cfp_pkg::CH_STOP);
    endtask

    task automatic add_noise();
        int i;
        int n;
        n = $urandom_range(1, 8);
        for (i = 0; i < n; i++) begin
            if ($urandom_range(0, 3) == 0) pending_bytes.push_back(control_byte());
            else pending_bytes.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    always @(posedge i_clk) begin : drive_proc
        logic       next_valid;
        logic [7:0] next_byte;
        if (!i_rst_n) begin
            rx_ch.valid   <= 1'b0;
            rx_ch.rx_byte <= 8'd0;
        end else begin
            next_valid = rx_ch.valid;
            next_byte  = rx_ch.rx_byte;
            if (rx_ch.valid && rx_ch.ready) begin
                advance_parser(rx_ch.rx_byte);
                bytes_taken++;
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_bytes.size() > 0) begin
                    if (idling_allowed() && $urandom_range(0, 9) == 0) begin
                        send_gap = $urandom_range(0, 13);
                    end else begin
                        next_valid = 1'b1;
                        next_byte  = pending_bytes.pop_front();
                    end
                end
            end
            rx_ch.valid   <= next_valid;
            rx_ch.rx_byte <= next_byte;
        end
    end

    always @(posedge i_clk) begin : watch_proc
        cfp_pkg::t_result want;
        logic             next_ready;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                results_seen++;
                if (frame_results_due.size() == 0) begin
                    error_count++;
                    if (error_count <= 10)
                        $display("unexpected result: kind %0d slot %0d value %0d len %0d",
                                 res_ch.frame_kind, res_ch.slot, res_ch.value,
                                 res_ch.text_length);
                end else begin
                    want = frame_results_due.pop_front();
                    if (want.frame_kind == cfp_pkg::KIND_STORED) stored_seen++;
                    if (want.frame_kind == cfp_pkg::KIND_BAD_SLOT) bad_slot_seen++;
                    if (want.text_overflow) long_seen++;
                    if (res_ch.frame_kind !== want.frame_kind || res_ch.slot !== want.slot ||
                        res_ch.value !== want.value || res_ch.text_chars !== want.text_chars ||
                        res_ch.text_length !== want.text_length ||
                        res_ch.text_overflow !== want.text_overflow) begin
                        error_count++;
                        if (error_count <= 10)
                            $display({"mismatch at result %0d (expected/actual): kind %0d/%0d",
                                      " slot %0d/%0d value %0d/%0d chars %h/%h",
                                      " len %0d/%0d ovf %0b/%0b"},
                                     results_seen, want.frame_kind, res_ch.frame_kind,
                                     want.slot, res_ch.slot, $signed(want.value), res_ch.value,
                                     want.text_chars, res_ch.text_chars,
                                     want.text_length, res_ch.text_length,
                                     want.text_overflow, res_ch.text_overflow);
                    end
                end
            end
            if (sink_gap > 0) begin
                sink_gap--;
                next_ready = 1'b0;
            end else if (idling_allowed() && $urandom_range(0, 9) == 0) begin
                sink_gap   = $urandom_range(0, 13);
                next_ready = 1'b0;
            end else begin
                next_ready = 1'b1;
            end
            res_ch.ready <= next_ready;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, frame_results_due.size());
            $display("command_frame_parser_unit_tb: done, errors");
            $finish;
        end
    end

    initial begin
        int frame_no;
        int pick;
        i_rst_n = 1'b0;

        pending_bytes.push_back(cfp_pkg::CH_STOP);
        add_text(",!3-123.");
        pending_bytes.push_back(cfp_pkg::CH_START);
        pending_bytes.push_back(8'h00);
        pending_bytes.push_back(8'hFF);
        add_text("ab!7 9.");
        pending_bytes.push_back(cfp_pkg::CH_STOP);
        add_text("!,5+7.");

        frame_no = 0;
        while (pending_bytes.size() < ITEM_TARGET) begin
            pick = $urandom_range(0, 99);
            if (frame_no == 30 || frame_no == 90) add_name_frame($urandom_range(256, 270));
            else if (pick < 50) add_value_frame();
            else if (pick < 80)
                add_name_frame(($urandom_range(0, 3) == 0) ? $urandom_range(9, 20)
                                                          : $urandom_range(0, 8));
            else add_noise();
            frame_no++;
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_bytes.size() != 0 || rx_ch.valid) @(negedge i_clk);
        while (frame_results_due.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("sent %0d bytes; checked %0d frame results", bytes_taken, results_seen);
        $display("  %0d stored to a slot, %0d with a bad slot, %0d with overlong text",
                 stored_seen, bad_slot_seen, long_seen);
        if (error_count == 0) begin
            $display("command_frame_parser_unit_tb: done, clean");
        end else begin
            $display("%0d errors", error_count);
            $display("command_frame_parser_unit_tb: done, errors");
        end
        $finish;
    end

endmodule

// ===== command_frame_parser_unit.f =====
sv/cfp_pkg.sv
sv/cfp_if.sv
sv/cfp_core.sv
sv/command_frame_parser_unit.sv
verif/command_frame_parser_unit_tb.sv
